>>> src/sector_buffer_cache_assert.svh
// Assertion macros for the sector buffer cache.
// Included by the top level; depends on nothing else.
`ifndef SECTOR_BUFFER_CACHE_ASSERT_SVH
`define SECTOR_BUFFER_CACHE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define SBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sector_buffer_cache: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define SBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sector_buffer_cache: next-cycle check failed");
`else
`define SBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/sbc_pkg.sv
// Shared types, codes and helpers of the sector buffer cache.
// Used by sbc_class, sbc_engine and sector_buffer_cache; depends on nothing.
package sbc_pkg;

    localparam int SBC_WAYS  = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FAT_OFFSET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_OFFSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SHIFT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_LIMIT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FAT_SIZE      = 3'd6;

    localparam logic [1:0] KIND_FAT  = 2'd0;
    localparam logic [1:0] KIND_DIR  = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_GRANT = 2'd2;
    localparam logic [1:0] ACT_ERROR = 2'd3;

    localparam logic [1:0] MS_POSSIBLE = 2'd1;
    localparam logic [1:0] MS_DEFINITE = 2'd2;

    typedef struct packed {
        logic signed [31:0] fat_offset;
        logic signed [31:0] dir_offset;
        logic signed [31:0] data_offset;
        logic        [3:0]  cluster_shift;
        logic signed [15:0] data_start_cluster;
        logic        [30:0] dir_record_limit;
        logic        [15:0] fat_size;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] record;
        logic        [4:0]  drive;
        logic               write_intent;
        logic        [1:0]  media_status;
    } t_in;

    typedef struct packed {
        logic        [1:0]  action;
        logic signed [31:0] sector;
        logic        [4:0]  disk;
        logic        [1:0]  buffer;
        logic               was_hit;
        logic               last;
    } t_out;

    // Tag row of one cache entry.
    typedef struct packed {
        logic        valid;
        logic        dirty;
        logic [1:0]  kind;
        logic [4:0]  drive;
        logic [31:0] record;
    } t_tag;

    // Sector offset that belongs to a record kind.
    function automatic logic [31:0] kind_offset(input t_cfg c, input logic [1:0] k);
        logic [31:0] off;
        case (k)
            KIND_FAT: off = c.fat_offset;
            KIND_DIR: off = c.dir_offset;
            default:  off = c.data_offset;
        endcase
        return off;
    endfunction

endpackage

>>> src/sbc_class.sv
// Record classifier: FAT, directory or data, from the configured layout.
// Depends on sbc_pkg.
module sbc_class import sbc_pkg::*; (
    input  t_cfg               i_cfg,
    input  logic signed [31:0] i_record,
    output logic        [1:0]  o_kind
);

    logic signed [31:0] rec_sh;
    logic signed [31:0] off_sh;
    logic        [15:0] cl;
    logic        [15:0] delta;
    logic        [15:0] lim;
    logic               is_fat;
    logic               is_dir;

    always_comb begin
        rec_sh = $signed(i_record) >>> i_cfg.cluster_shift;
        off_sh = $signed(i_cfg.data_offset) >>> i_cfg.cluster_shift;
        cl     = rec_sh[15:0];
        lim    = off_sh[15:0];
        delta  = 16'(i_cfg.data_start_cluster) - cl;
        // A record lies in the FAT span when its cluster is below the
        // first data cluster by at most the data offset in clusters.
        is_fat = ($signed(delta) > 16'sd0) && ($signed(delta) <= $signed(lim));
        is_dir = $signed(i_record) >= $signed({1'b0, i_cfg.dir_record_limit});
        if (is_fat) begin
            o_kind = KIND_FAT;
        end else if (is_dir) begin
            o_kind = KIND_DIR;
        end else begin
            o_kind = KIND_DATA;
        end
    end

endmodule

>>> src/sbc_engine.sv
// Request sequencer of the sector buffer cache with its tag and rank memories
// and the result register. Depends on sbc_pkg and sbc_class.
module sbc_engine import sbc_pkg::*; #(
    parameter int WAYS = SBC_WAYS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int W  = WAYS;
    localparam int N  = 2 * WAYS;
    localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int IW = $clog2(N);
    localparam int CW = RW + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLASS  = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_VLOAD  = 4'd4;
    localparam logic [3:0] S_FLUSH  = 4'd5;
    localparam logic [3:0] S_MIRROR = 4'd6;
    localparam logic [3:0] S_READ   = 4'd7;
    localparam logic [3:0] S_RANK   = 4'd8;
    localparam logic [3:0] S_GRANT  = 4'd9;

    // Entry address: the FAT list first, then the directory/data list.
    function automatic logic [IW-1:0] idx_of(input logic [1:0] kind,
                                             input logic [RW-1:0] way);
        logic [IW:0] sum;
        sum = (kind != KIND_FAT) ? (IW+1)'(W) : '0;
        sum = sum + (IW+1)'(way);
        return sum[IW-1:0];
    endfunction

    function automatic logic [1:0] buf_of(input logic [IW-1:0] idx);
        logic [IW+1:0] ext;
        ext = (IW+2)'(idx);
        return ext[1:0];
    endfunction

    // Memories and their read registers.
    t_tag          r_mem_tag  [N];
    logic [RW-1:0] r_mem_rank [N];
    logic [N-1:0]  r_live;
    t_tag          r_q_tag;
    logic [RW-1:0] r_q_rank;
    logic          r_q_live;

    // Control state.
    logic [3:0]    r_state,     n_state;
    logic [CW-1:0] r_cnt,       n_cnt;
    logic          r_pend,      n_pend;
    logic [RW-1:0] r_pway,      n_pway;
    logic          r_hit_found, n_hit_found;
    logic          r_emp_found, n_emp_found;
    logic          r_out_valid, n_out_valid;

    // Payload state.
    t_in           r_req,      n_req;
    logic [1:0]    r_kind,     n_kind;
    logic [RW-1:0] r_hit_way,  n_hit_way;
    logic [RW-1:0] r_hit_rank, n_hit_rank;
    logic [RW-1:0] r_emp_way,  n_emp_way;
    logic [RW-1:0] r_emp_rank, n_emp_rank;
    logic [RW-1:0] r_lru_way,  n_lru_way;
    logic [RW-1:0] r_vway,     n_vway;
    logic [RW-1:0] r_vrank,    n_vrank;
    t_tag          r_vtag,     n_vtag;
    logic          r_keep,     n_keep;
    logic [31:0]   r_mbase,    n_mbase;
    t_out          r_out,      n_out;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_tag          wr_tag;
    logic [RW-1:0] wr_rank;
    logic          emit;
    t_out          emit_data;
    logic          out_free;
    t_tag          eff_tag;
    logic [RW-1:0] eff_rank;
    logic          match;
    logic          keep;
    logic [RW-1:0] victim_way;
    logic [IW-1:0] vidx;
    logic [1:0]    class_kind;

    sbc_class u_class (
        .i_cfg    (i_cfg),
        .i_record (r_req.record),
        .o_kind   (class_kind)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pend      = 1'b0;
        n_pway      = r_pway;
        n_hit_found = r_hit_found;
        n_emp_found = r_emp_found;
        n_req       = r_req;
        n_kind      = r_kind;
        n_hit_way   = r_hit_way;
        n_hit_rank  = r_hit_rank;
        n_emp_way   = r_emp_way;
        n_emp_rank  = r_emp_rank;
        n_lru_way   = r_lru_way;
        n_vway      = r_vway;
        n_vrank     = r_vrank;
        n_vtag      = r_vtag;
        n_keep      = r_keep;
        n_mbase     = r_mbase;

        rd_en     = 1'b0;
        rd_addr   = idx_of(r_kind, r_cnt[RW-1:0]);
        wr_en     = 1'b0;
        wr_addr   = idx_of(r_kind, r_pway);
        wr_tag    = '0;
        wr_rank   = '0;
        emit      = 1'b0;
        emit_data = '0;
        out_free  = !r_out_valid || !i_out_stall;

        // An entry never written since reset reads as invalid, ranked by way.
        eff_tag  = r_q_live ? r_q_tag : '0;
        eff_rank = r_q_live ? r_q_rank : r_pway;
        match    = eff_tag.valid && (eff_tag.drive == r_req.drive) &&
                   (eff_tag.record == r_req.record);
        keep     = r_hit_found && (r_req.media_status != MS_POSSIBLE);
        victim_way = r_hit_found ? r_hit_way : (r_emp_found ? r_emp_way : r_lru_way);
        vidx     = idx_of(r_kind, r_vway);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                n_kind      = class_kind;
                n_hit_found = 1'b0;
                n_emp_found = 1'b0;
                n_cnt       = '0;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                if (r_cnt < CW'(W)) begin
                    rd_en  = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                    n_pend = 1'b1;
                    n_pway = r_cnt[RW-1:0];
                end
                if (r_pend) begin
                    if (match && (!r_hit_found || (eff_rank < r_hit_rank))) begin
                        n_hit_found = 1'b1;
                        n_hit_way   = r_pway;
                        n_hit_rank  = eff_rank;
                    end
                    // The invalid entry latest in recency order is preferred.
                    if (!eff_tag.valid && (!r_emp_found || (eff_rank > r_emp_rank))) begin
                        n_emp_found = 1'b1;
                        n_emp_way   = r_pway;
                        n_emp_rank  = eff_rank;
                    end
                    if (eff_rank == RW'(W - 1)) begin
                        n_lru_way = r_pway;
                    end
                    if (r_pway == RW'(W - 1)) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (r_hit_found && (r_req.media_status == MS_DEFINITE)) begin
                    emit             = 1'b1;
                    emit_data.action = ACT_ERROR;
                    emit_data.disk   = r_req.drive;
                    emit_data.buffer = buf_of(idx_of(r_kind, r_hit_way));
                    emit_data.last   = 1'b1;
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_of(r_kind, victim_way);
                    n_vway  = victim_way;
                    n_pway  = victim_way;
                    n_state = S_VLOAD;
                end
            end
            S_VLOAD: begin
                n_vtag  = eff_tag;
                n_vrank = eff_rank;
                n_keep  = keep;
                n_mbase = i_cfg.fat_offset - 32'(i_cfg.fat_size);
                n_cnt   = '0;
                if (keep) begin
                    n_state = S_RANK;
                end else if (eff_tag.valid && eff_tag.dirty) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_READ;
                end
            end
            S_FLUSH: begin
                emit             = 1'b1;
                emit_data.action = ACT_WRITE;
                emit_data.sector = r_vtag.record + kind_offset(i_cfg, r_vtag.kind);
                emit_data.disk   = r_vtag.drive;
                emit_data.buffer = buf_of(vidx);
                if (out_free) begin
                    n_state = (r_vtag.kind == KIND_FAT) ? S_MIRROR : S_READ;
                end
            end
            S_MIRROR: begin
                emit             = 1'b1;
                emit_data.action = ACT_WRITE;
                emit_data.sector = r_vtag.record + r_mbase;
                emit_data.disk   = r_vtag.drive;
                emit_data.buffer = buf_of(vidx);
                if (out_free) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                emit             = 1'b1;
                emit_data.action = ACT_READ;
                emit_data.sector = r_req.record + kind_offset(i_cfg, r_kind);
                emit_data.disk   = r_req.drive;
                emit_data.buffer = buf_of(vidx);
                if (out_free) begin
                    n_vtag.valid  = 1'b1;
                    n_vtag.dirty  = 1'b0;
                    n_vtag.kind   = r_kind;
                    n_vtag.drive  = r_req.drive;
                    n_vtag.record = r_req.record;
                    n_cnt         = '0;
                    n_state       = S_RANK;
                end
            end
            S_RANK: begin
                if (r_cnt < CW'(W)) begin
                    rd_en  = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                    n_pend = 1'b1;
                    n_pway = r_cnt[RW-1:0];
                end
                // Write back each row in the cycle after its read; the next read
                // always goes to another entry.
                if (r_pend) begin
                    wr_en = 1'b1;
                    if (r_pway == r_vway) begin
                        wr_tag       = r_vtag;
                        wr_tag.dirty = r_vtag.dirty | r_req.write_intent;
                        wr_rank      = '0;
                    end else begin
                        wr_tag  = eff_tag;
                        wr_rank = (eff_rank < r_vrank) ? (eff_rank + RW'(1)) : eff_rank;
                    end
                    if (r_pway == RW'(W - 1)) begin
                        n_state = S_GRANT;
                    end
                end
            end
            S_GRANT: begin
                emit              = 1'b1;
                emit_data.action  = ACT_GRANT;
                emit_data.disk    = r_req.drive;
                emit_data.buffer  = buf_of(vidx);
                emit_data.was_hit = r_keep;
                emit_data.last    = 1'b1;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit && out_free) begin
            n_out_valid = 1'b1;
            n_out       = emit_data;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
            n_out       = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_pway      <= '0;
            r_hit_found <= 1'b0;
            r_emp_found <= 1'b0;
            r_out_valid <= 1'b0;
            r_live      <= '0;
            r_q_live    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_pway      <= n_pway;
            r_hit_found <= n_hit_found;
            r_emp_found <= n_emp_found;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_live[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_q_live <= r_live[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_kind     <= n_kind;
        r_hit_way  <= n_hit_way;
        r_hit_rank <= n_hit_rank;
        r_emp_way  <= n_emp_way;
        r_emp_rank <= n_emp_rank;
        r_lru_way  <= n_lru_way;
        r_vway     <= n_vway;
        r_vrank    <= n_vrank;
        r_vtag     <= n_vtag;
        r_keep     <= n_keep;
        r_mbase    <= n_mbase;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_tag[wr_addr]  <= wr_tag;
            r_mem_rank[wr_addr] <= wr_rank;
        end
        if (rd_en) begin
            r_q_tag  <= r_mem_tag[rd_addr];
            r_q_rank <= r_mem_rank[rd_addr];
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> src/sector_buffer_cache.sv
// Top level of the sector buffer cache: configuration registers and the engine.
// Depends on sbc_pkg, sbc_engine and sector_buffer_cache_assert.svh.
//
// Usage: a request (record, drive, write_intent, media_status) is a transfer on
// the input channel, taken when i_in_valid is high and o_in_stall is low. The
// block answers with one to four result transfers on the output channel, in
// order: write-backs of a dirty victim (a FAT victim also to the mirror FAT),
// the read of the new record, then the grant, or a single media-changed error.
// The final result of a request carries last = 1.
// A request searches its list in the tag memory, one entry read per cycle; unless it
// ends in an error, a second pass over the list rewrites the recency ranks.
// The result sits in an output register; the engine waits while it is full and
// stalled, and o_in_stall stays high until the last result is registered.
// Reset, synchronous and active low, marks every entry invalid, restores the
// way-order ranks and the register defaults; no clearing pass is needed.
// Configuration writes (always ready) are to be made only while idle.
`include "sector_buffer_cache_assert.svh"

module sector_buffer_cache import sbc_pkg::*; #(
    parameter int WAYS_PER_LIST = SBC_WAYS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cfg r_cfg;

    // The register file takes a write in every cycle; an index beyond the
    // list is accepted and dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fat_offset         <= '0;
            r_cfg.dir_offset         <= '0;
            r_cfg.data_offset        <= '0;
            r_cfg.cluster_shift      <= 4'd1;
            r_cfg.data_start_cluster <= 16'sd2;
            r_cfg.dir_record_limit   <= '0;
            r_cfg.fat_size           <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FAT_OFFSET:    r_cfg.fat_offset         <= i_cfg_data;
                CFG_DIR_OFFSET:    r_cfg.dir_offset         <= i_cfg_data;
                CFG_DATA_OFFSET:   r_cfg.data_offset        <= i_cfg_data;
                CFG_CLUSTER_SHIFT: r_cfg.cluster_shift      <= i_cfg_data[3:0];
                CFG_DATA_START:    r_cfg.data_start_cluster <= i_cfg_data[15:0];
                CFG_DIR_LIMIT:     r_cfg.dir_record_limit   <= i_cfg_data[30:0];
                CFG_FAT_SIZE:      r_cfg.fat_size           <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    sbc_engine #(
        .WAYS (WAYS_PER_LIST)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // A request that has just been taken keeps the input stalled.
    `SBC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // While a result that is not the last one is shown, the request is in flight.
    `SBC_ASSERT_IMPL(a_busy_mid_request, i_clk, i_rst_n, o_out_valid && !o_out_data.last, o_in_stall)
    // An error ends its request.
    `SBC_ASSERT_IMPL(a_error_is_last, i_clk, i_rst_n, o_out_valid && (o_out_data.action == ACT_ERROR), o_out_data.last)
    // Only a grant can report a hit.
    `SBC_ASSERT_IMPL(a_hit_on_grant, i_clk, i_rst_n, o_out_valid && o_out_data.was_hit, o_out_data.action == ACT_GRANT)

endmodule

>>> tb/sv/sector_buffer_cache_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sector buffer cache tag and recency controller.
// Depends on sbc_pkg and sector_buffer_cache; a built-in predictor checks every result.
module sector_buffer_cache_tb;
    import sbc_pkg::*;

    // Sizes of the cache and of the run.
    localparam int NUM_ENTRIES  = 2 * SBC_WAYS;
    localparam int RANK_W       = (SBC_WAYS > 1) ? $clog2(SBC_WAYS) : 1;
    localparam int POOL_SIZE    = 10;
    localparam int RANDOM_ITEMS = 84;
    localparam int TAIL_CYCLES  = 2 * SBC_WAYS + 16;
    // Budget of the run, with room for long output stalls.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 10;

    // Media status codes that the package does not name.
    localparam logic [1:0] MS_UNCHANGED = 2'd0;
    localparam logic [1:0] MS_RESERVED  = 2'd3;

    // All inputs of the block hold known values from time zero.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data  = '0;

    // Predictor state: its own copy of the layout registers, the tag rows and the ranks.
    t_cfg              layout;
    t_tag              tag_mem  [NUM_ENTRIES];
    logic [RANK_W-1:0] lru_rank [NUM_ENTRIES];

    // Results that accepted requests are still owed, oldest first.
    t_out pending_results[$];

    // Records and drives that random traffic reuses, so that hits and evictions are common.
    logic [31:0] rec_pool   [POOL_SIZE];
    logic [4:0]  drive_pool [2];

    // Idling of both sides, in percent of cycles, and the long output hold-off.
    int gap_pct    = 0;
    int stall_pct  = 0;
    int hold_left  = 0;
    int fail_count = 0;

    sector_buffer_cache dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial forever #5 i_clk = ~i_clk;

    // The run is ended here if the block hangs or loses a result.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("sector_buffer_cache test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Reset state: register defaults, every entry invalid, ranks in way order.
    function automatic void predictor_reset();
        layout                    = '0;
        layout.cluster_shift      = 4'd1;
        layout.data_start_cluster = 16'sd2;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            tag_mem[i]  = '0;
            lru_rank[i] = RANK_W'(i % SBC_WAYS);
        end
    endfunction

    function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [31:0] value);
        case (idx)
            CFG_FAT_OFFSET:    layout.fat_offset         = value;
            CFG_DIR_OFFSET:    layout.dir_offset         = value;
            CFG_DATA_OFFSET:   layout.data_offset        = value;
            CFG_CLUSTER_SHIFT: layout.cluster_shift      = value[3:0];
            CFG_DATA_START:    layout.data_start_cluster = value[15:0];
            CFG_DIR_LIMIT:     layout.dir_record_limit   = value[30:0];
            CFG_FAT_SIZE:      layout.fat_size           = value[15:0];
            default: ;
        endcase
    endfunction

    // A record is FAT when its cluster lies within the span below the data area that the
    // data offset allows; all cluster arithmetic is 16-bit signed. Otherwise the
    // directory limit splits directory records from data records.
    function automatic logic [1:0] record_kind(input logic [31:0] rec);
        logic [15:0]        cluster;
        logic signed [15:0] span;
        logic signed [15:0] reach;
        cluster = 16'($signed(rec) >>> layout.cluster_shift);
        span    = layout.data_start_cluster - cluster;
        reach   = 16'($signed(layout.data_offset) >>> layout.cluster_shift);
        if (span > 0 && span <= reach) begin
            return KIND_FAT;
        end
        if ($signed(rec) >= $signed({1'b0, layout.dir_record_limit})) begin
            return KIND_DIR;
        end
        return KIND_DATA;
    endfunction

    function automatic logic [31:0] area_offset(input logic [1:0] kind);
        case (kind)
            KIND_FAT: return layout.fat_offset;
            KIND_DIR: return layout.dir_offset;
            default:  return layout.data_offset;
        endcase
    endfunction

    function automatic void push_result(input logic [1:0] action, input logic [31:0] sector,
                                        input logic [4:0] disk, input int entry,
                                        input logic hit, input logic final_one);
        t_out res;
        res.action  = action;
        res.sector  = sector;
        res.disk    = disk;
        res.buffer  = 2'(entry);
        res.was_hit = hit;
        res.last    = final_one;
        pending_results.push_back(res);
    endfunction

    // Write back a dirty entry before it is reused; a FAT entry also goes to the mirror FAT.
    function automatic void write_back_entry(input int entry);
        if (!tag_mem[entry].valid || !tag_mem[entry].dirty) begin
            tag_mem[entry].valid = 1'b0;
            return;
        end
        push_result(ACT_WRITE, tag_mem[entry].record + area_offset(tag_mem[entry].kind),
                    tag_mem[entry].drive, entry, 1'b0, 1'b0);
        if (tag_mem[entry].kind == KIND_FAT) begin
            push_result(ACT_WRITE,
                        tag_mem[entry].record + layout.fat_offset - {16'b0, layout.fat_size},
                        tag_mem[entry].drive, entry, 1'b0, 1'b0);
        end
        tag_mem[entry].dirty = 1'b0;
    endfunction

    // Works out every result that one accepted request causes and updates the tag state.
    function automatic void predict_request(input t_in req);
        logic [1:0] kind;
        logic       hit_grant;
        int         base;
        int         hit;
        int         empty;
        int         lru;
        int         victim;
        int         idx;
        kind      = record_kind(req.record);
        base      = (kind == KIND_FAT) ? 0 : SBC_WAYS;
        hit       = -1;
        empty     = -1;
        lru       = -1;
        hit_grant = 1'b0;

        // Search from the most to the least recently used entry of the list.
        for (int r = 0; r < SBC_WAYS && hit < 0; r++) begin
            for (int w = 0; w < SBC_WAYS; w++) begin
                idx = base + w;
                if (lru_rank[idx] != r) continue;
                if (tag_mem[idx].valid && tag_mem[idx].drive == req.drive &&
                    tag_mem[idx].record == req.record) begin
                    hit = idx;
                    break;
                end
                if (!tag_mem[idx].valid) empty = idx;
                lru = idx;
            end
        end
        if (lru < 0) lru = base;

        // A definite media change on a hit is reported and leaves the state alone.
        if (hit >= 0 && req.media_status == MS_DEFINITE) begin
            push_result(ACT_ERROR, '0, req.drive, hit, 1'b0, 1'b1);
            return;
        end

        if (hit >= 0 && req.media_status != MS_POSSIBLE) begin
            victim    = hit;
            hit_grant = 1'b1;
        end else begin
            // Miss, or a possible media change that forces a reload of the hit entry.
            victim = (hit >= 0) ? hit : ((empty >= 0) ? empty : lru);
            write_back_entry(victim);
            push_result(ACT_READ, req.record + area_offset(kind), req.drive, victim,
                        1'b0, 1'b0);
            tag_mem[victim].record = req.record;
            tag_mem[victim].dirty  = 1'b0;
            tag_mem[victim].kind   = kind;
            tag_mem[victim].drive  = req.drive;
            tag_mem[victim].valid  = 1'b1;
        end

        // Move the used entry to the front of its list.
        for (int i = base; i < base + SBC_WAYS; i++) begin
            if (lru_rank[i] < lru_rank[victim]) lru_rank[i] = lru_rank[i] + 1'b1;
        end
        lru_rank[victim] = '0;
        if (req.write_intent) tag_mem[victim].dirty = 1'b1;

        push_result(ACT_GRANT, '0, req.drive, victim, hit_grant, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Result checking and output stalls
    // ------------------------------------------------------------------

    function automatic void note_failure(input string what);
        if (fail_count < MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, what);
        fail_count++;
    endfunction

    function automatic void check_result(input t_out got);
        t_out want;
        if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected result: action %0d sector %h disk %0d buffer %0d",
                                   got.action, got.sector, got.disk, got.buffer));
            return;
        end
        want = pending_results.pop_front();
        if (got.action !== want.action || got.sector !== want.sector ||
            got.disk !== want.disk || got.buffer !== want.buffer ||
            got.was_hit !== want.was_hit || got.last !== want.last) begin
            note_failure($sformatf({"result mismatch: expected action %0d sector %h disk %0d ",
                                    "buffer %0d hit %0d last %0d, got action %0d sector %h ",
                                    "disk %0d buffer %0d hit %0d last %0d"},
                                   want.action, want.sector, want.disk, want.buffer,
                                   want.was_hit, want.last, got.action, got.sector, got.disk,
                                   got.buffer, got.was_hit, got.last));
        end
    endfunction

    // A result transfer happens at an edge where o_out_valid is high and our stall is low.
    // Both are read right after the edge, before any update of this time step lands.
    // The stall for the next cycle is drawn here too, or held high during a hold-off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) check_result(o_out_data);
        i_out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);
    end

    // Counts down the long output hold-off that fills the block up.
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one request and holds it until the block takes it, then may go idle for a
    // while. Valid stays high when the next request follows at once. Called at an edge.
    task automatic send_req(input t_in req);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_request(req);
        if ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < gap_pct);
        end
    endtask

    // Stops offering requests and waits until every owed result has come and the block
    // takes input again, so that it is idle.
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0 || o_in_stall === 1'b1) @(posedge i_clk);
    endtask

    // Leaves the configuration valid high; the caller lowers it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        shadow_write(idx, value);
    endtask

    // Chooses records for random traffic: a few of each kind where the layout has them,
    // drawn near the FAT span, near the directory limit, small, or anywhere at all.
    function automatic void build_pool();
        int          per_kind [3];
        int          filled;
        logic [31:0] cand;
        logic [1:0]  kind;
        per_kind = '{0, 0, 0};
        filled   = 0;
        for (int tries = 0; filled < POOL_SIZE; tries++) begin
            case ($urandom_range(0, 3))
                0: cand = $urandom_range(0, 1023);
                1: cand = {1'b0, layout.dir_record_limit} + $urandom_range(0, 15) - 8;
                2: cand = ((32'($signed(layout.data_start_cluster)) - $urandom_range(1, 40))
                           << layout.cluster_shift)
                          | ($urandom & ((32'd1 << layout.cluster_shift) - 1));
                default: cand = $urandom;
            endcase
            kind = record_kind(cand);
            if (per_kind[kind] < 4 || tries > 1500) begin
                rec_pool[filled] = cand;
                per_kind[kind]++;
                filled++;
            end
        end
        drive_pool[0] = 5'($urandom_range(0, 31));
        drive_pool[1] = ~drive_pool[0];
    endfunction

    // Rewrites every register of the layout once the block is idle.
    task automatic apply_layout(input logic [31:0] fat_off, input logic [31:0] dir_off,
                                input logic [31:0] data_off, input logic [3:0] shift,
                                input logic [15:0] start_cl, input logic [30:0] dir_lim,
                                input logic [15:0] fat_len);
        wait_quiet();
        write_reg(CFG_FAT_OFFSET, fat_off);
        write_reg(CFG_DIR_OFFSET, dir_off);
        write_reg(CFG_DATA_OFFSET, data_off);
        write_reg(CFG_CLUSTER_SHIFT, {28'b0, shift});
        write_reg(CFG_DATA_START, {{16{start_cl[15]}}, start_cl});
        write_reg(CFG_DIR_LIMIT, {1'b0, dir_lim});
        write_reg(CFG_FAT_SIZE, {16'b0, fat_len});
        i_cfg_valid <= 1'b0;
        build_pool();
    endtask

    function automatic t_in make_req(input logic [31:0] rec, input logic [4:0] drv,
                                     input logic wr, input logic [1:0] ms);
        t_in req;
        req.record       = rec;
        req.drive        = drv;
        req.write_intent = wr;
        req.media_status = ms;
        return req;
    endfunction

    // Mostly pool records on the pool drives, with some noise over the full field ranges.
    function automatic t_in random_request();
        t_in req;
        int  pick;
        req.record = ($urandom_range(0, 99) < 85) ? rec_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                  : $urandom;
        req.drive  = ($urandom_range(0, 99) < 85) ? drive_pool[$urandom_range(0, 1)]
                                                  : 5'($urandom);
        req.write_intent = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 68)      req.media_status = MS_UNCHANGED;
        else if (pick < 84) req.media_status = MS_POSSIBLE;
        else if (pick < 96) req.media_status = MS_DEFINITE;
        else                req.media_status = MS_RESERVED;
        return req;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) send_req(random_request());
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        gap_pct   = sender_pct;
        stall_pct = receiver_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset layout: no FAT span, a directory limit of zero, so non-negative records are
    // directory records and negative ones are data records.
    task automatic test_reset_defaults();
        set_idling(0, 0);
        send_req(make_req(32'd0, 5'd0, 1'b0, MS_UNCHANGED));
        send_req(make_req(32'hFFFF_FFFF, 5'd0, 1'b1, MS_UNCHANGED));
        send_req(make_req(32'hFFFF_FFFF, 5'd0, 1'b0, MS_UNCHANGED));
        send_req(make_req(32'd0, 5'd31, 1'b1, MS_RESERVED));
        send_req(make_req(32'd2, 5'd0, 1'b1, MS_UNCHANGED));
    endtask

    // A layout with FAT records 16 to 79, data below 16 and from 80 to 199, and directory
    // records from 200 up. The sequence walks through misses into free entries, dirty FAT
    // evictions with mirror writes, hits, media change errors, forced reloads, a media
    // status of three, the same record on another drive and the record extremes.
    task automatic test_directed_layout();
        set_idling(0, 0);
        apply_layout(32'd1000, 32'd5000, 32'd64, 4'd2, 16'd20, 31'd200, 16'd300);
        send_req(make_req(32'd16, 5'd3, 1'b1, MS_UNCHANGED));
        send_req(make_req(32'd79, 5'd3, 1'b1, MS_UNCHANGED));
        send_req(make_req(32'd40, 5'd3, 1'b0, MS_UNCHANGED));
        send_req(make_req(32'd40, 5'd3, 1'b1, MS_UNCHANGED));
        send_req(make_req(32'd40, 5'd3, 1'b0, MS_DEFINITE));
        send_req(make_req(32'd40, 5'd3, 1'b0, MS_POSSIBLE));
        send_req(make_req(32'd40, 5'd3, 1'b0, MS_RESERVED));
        send_req(make_req(32'd40, 5'd4, 1'b0, MS_UNCHANGED));
        send_req(make_req(32'd15, 5'd0, 1'b1, MS_UNCHANGED));
        send_req(make_req(32'd80, 5'd0, 1'b1, MS_UNCHANGED));
        send_req(make_req(32'd199, 5'd31, 1'b1, MS_UNCHANGED));
        send_req(make_req(32'd200, 5'd31, 1'b1, MS_UNCHANGED));
        send_req(make_req(32'h7FFF_FFFF, 5'd31, 1'b0, MS_UNCHANGED));
        send_req(make_req(32'h8000_0000, 5'd0, 1'b1, MS_DEFINITE));
        send_req(make_req(32'h8000_0000, 5'd0, 1'b0, MS_DEFINITE));
        send_req(make_req(32'hFFFF_FFFF, 5'd0, 1'b0, MS_POSSIBLE));
        send_req(make_req(32'h8000_0000, 5'd0, 1'b0, MS_POSSIBLE));
        send_req(make_req(32'd79, 5'd3, 1'b0, MS_UNCHANGED));
        send_req(make_req(32'd79, 5'd3, 1'b0, MS_POSSIBLE));
        send_req(make_req(32'd79, 5'd3, 1'b0, MS_DEFINITE));
    endtask

    // Back-to-back traffic with neither side idling.
    task automatic test_quiet_traffic();
        set_idling(0, 0);
        apply_layout(32'd1000, 32'd5000, 32'd64, 4'd2, 16'd20, 31'd200, 16'd300);
        run_random(RANDOM_ITEMS);
    endtask

    // Upper extremes of the layout; the sender often goes idle after a request.
    task automatic test_sender_gaps();
        set_idling(65, 0);
        apply_layout(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 4'd15, 16'h7FFF,
                     31'h7FFF_FFFF, 16'hFFFF);
        run_random(RANDOM_ITEMS);
    endtask

    // Lower extremes with a wide FAT span; the receiver stalls most cycles.
    task automatic test_receiver_stalls();
        set_idling(0, 65);
        apply_layout(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_7FFF, 4'd0, 16'h8000,
                     31'd0, 16'd0);
        run_random(RANDOM_ITEMS);
    endtask

    // A random layout; the sender idles after a third of its requests, the receiver stalls a third of the cycles.
    task automatic test_mixed_idling();
        set_idling(34, 34);
        apply_layout($urandom, $urandom,
                     ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(1, 4096),
                     4'($urandom_range(0, 15)), 16'($urandom), 31'($urandom),
                     16'($urandom));
        run_random(RANDOM_ITEMS);
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so the block
    // fills up and stalls its input. The following idle wait lets every result drain.
    task automatic test_input_backpressure();
        set_idling(0, 0);
        apply_layout(32'd77, 32'hFFFF_FF00, 32'h8000_0000, 4'd1, 16'd5, 31'd1000, 16'hFFFF);
        hold_left <= 300;
        run_random(20);
        wait_quiet();
    endtask

    initial begin
        predictor_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_layout();
        test_quiet_traffic();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_input_backpressure();

        // Let any stray result show up before the verdict.
        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) note_failure("results still owed at the end");
        if (fail_count == 0) begin
            $display("sector_buffer_cache test passed");
        end else begin
            $display("sector_buffer_cache test failed");
        end
        $finish;
    end

endmodule
